@@ rtl/core/bsl_pkg.sv @@
// Shared types, codes and character classes for the byte stream lexer.
// No dependencies; imported by every module of the block.
package bsl_pkg;

	localparam int unsigned MAX_TOKEN_BYTES_DEF = 255;
	localparam int unsigned MAX_RES             = 3;
	localparam int unsigned RES_CNT_W           = 2;
	localparam int unsigned FIFO_DEPTH          = 4;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_NUMBER = 3'd1,
		MODE_IDENT  = 3'd2,
		MODE_STRING = 3'd3,
		MODE_SPACE  = 3'd4
	} lex_mode_t;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_VALUE = 2'd0;
	localparam kind_t KIND_DONE  = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;
	localparam kind_t KIND_END   = 2'd3;

	typedef logic [1:0] err_t;
	localparam err_t ERR_TOO_LONG     = 2'd0;
	localparam err_t ERR_QUOTE_MISMATCH = 2'd1;
	localparam err_t ERR_UNTERMINATED = 2'd2;

	typedef logic [3:0] tok_type_t;
	localparam tok_type_t TYPE_NUMBER = 4'd0;
	localparam tok_type_t TYPE_STRING = 4'd1;
	localparam tok_type_t TYPE_SEMI   = 4'd2;
	localparam tok_type_t TYPE_LT     = 4'd3;
	localparam tok_type_t TYPE_GT     = 4'd4;
	localparam tok_type_t TYPE_SLASH  = 4'd5;
	localparam tok_type_t TYPE_LBRACE = 4'd6;
	localparam tok_type_t TYPE_RBRACE = 4'd7;
	localparam tok_type_t TYPE_PIPE   = 4'd8;
	localparam tok_type_t TYPE_AMP    = 4'd9;
	localparam tok_type_t TYPE_EQUAL  = 4'd10;
	localparam tok_type_t TYPE_IDENT  = 4'd11;
	localparam tok_type_t TYPE_SPACE  = 4'd12;
	localparam tok_type_t TYPE_OTHER  = 4'd13;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		tok_type_t   ttype;
		logic [31:0] start_off;
		logic [31:0] end_off;
		err_t        err;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]  cnt;
		res_t [MAX_RES-1:0]    rec;
	} res_bundle_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] v, tok_type_t t,
			logic [31:0] s, logic [31:0] e, err_t er);
		res_t r;
		r.kind      = k;
		r.value     = v;
		r.ttype     = t;
		r.start_off = s;
		r.end_off   = e;
		r.err       = er;
		r.last      = 1'b0;
		return r;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_quote(logic [7:0] c);
		return (c == 8'h22) || (c == 8'h27);
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09);
	endfunction

	function automatic logic is_newline(logic [7:0] c);
		return (c == 8'h0A) || (c == 8'h0D);
	endfunction

	function automatic tok_type_t punct_type(logic [7:0] c);
		tok_type_t t;
		case (c)
			8'h3B:   t = TYPE_SEMI;
			8'h3C:   t = TYPE_LT;
			8'h3E:   t = TYPE_GT;
			8'h2F:   t = TYPE_SLASH;
			8'h7B:   t = TYPE_LBRACE;
			8'h7D:   t = TYPE_RBRACE;
			8'h7C:   t = TYPE_PIPE;
			8'h26:   t = TYPE_AMP;
			8'h3D:   t = TYPE_EQUAL;
			default: t = TYPE_OTHER;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/core/bsl_core.sv @@
// Input register and lexer state: classifies the held byte and forms up to three records.
// Depends on bsl_pkg.
module bsl_core #(
	parameter int unsigned MAX_TOKEN_BYTES = bsl_pkg::MAX_TOKEN_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_input,
	input  logic                 emit_space,
	input  logic                 room,
	output logic                 push,
	output bsl_pkg::res_bundle_t bundle
);
	import bsl_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_TOKEN_BYTES);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_BYTES - 2);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eoi_s1;

	lex_mode_t        mode_q, mode_n;
	logic [7:0]       quote_q, quote_n;
	logic [31:0]      tok_start_q, tok_start_n;
	logic [31:0]      pos_q, pos_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             halted_q, halted_n;

	logic                 at_end, start_new, do_append;
	logic [RES_CNT_W-1:0] n;
	res_t [MAX_RES-1:0]   rec;

	assign push     = valid_s1 && room;
	assign in_ready = !valid_s1 || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_byte;
			eoi_s1  <= end_of_input;
		end
	end

	always_comb begin
		mode_n      = mode_q;
		quote_n     = quote_q;
		tok_start_n = tok_start_q;
		pos_n       = pos_q;
		len_n       = len_q;
		halted_n    = halted_q;
		start_new   = 1'b0;
		do_append   = 1'b0;
		n           = '0;
		rec         = '0;
		at_end      = eoi_s1 || (char_s1 == 8'h00);

		if (halted_q) begin
			n = '0;
		end else if (at_end) begin
			if (mode_q == MODE_STRING) begin
				rec[n] = mk_res(KIND_ERROR, 8'h00, TYPE_NUMBER, tok_start_q, pos_q,
					ERR_UNTERMINATED);
				n = n + 1'b1;
			end else begin
				if (mode_q == MODE_NUMBER || mode_q == MODE_IDENT || mode_q == MODE_SPACE) begin
					rec[n] = mk_res(KIND_DONE, 8'h00,
						(mode_q == MODE_NUMBER) ? TYPE_NUMBER :
						(mode_q == MODE_IDENT) ? TYPE_IDENT : TYPE_SPACE,
						tok_start_q, pos_q, ERR_TOO_LONG);
					n = n + 1'b1;
				end
				rec[n] = mk_res(KIND_END, 8'h00, TYPE_NUMBER, pos_q, pos_q, ERR_TOO_LONG);
				n = n + 1'b1;
			end
			mode_n   = MODE_IDLE;
			halted_n = 1'b1;
		end else begin
			pos_n = pos_q + 32'd1;
			unique case (mode_q)
				MODE_NUMBER: begin
					if (is_digit(char_s1)) begin
						do_append = 1'b1;
					end else begin
						rec[n] = mk_res(KIND_DONE, 8'h00, TYPE_NUMBER, tok_start_q, pos_q,
							ERR_TOO_LONG);
						n = n + 1'b1;
						start_new = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_letter(char_s1) || is_digit(char_s1) || char_s1 == 8'h5F) begin
						do_append = 1'b1;
					end else begin
						rec[n] = mk_res(KIND_DONE, 8'h00, TYPE_IDENT, tok_start_q, pos_q,
							ERR_TOO_LONG);
						n = n + 1'b1;
						start_new = 1'b1;
					end
				end
				MODE_STRING: begin
					if (is_quote(char_s1)) begin
						if (char_s1 != quote_q) begin
							rec[n] = mk_res(KIND_ERROR, 8'h00, TYPE_NUMBER, tok_start_q,
								pos_q, ERR_QUOTE_MISMATCH);
							halted_n = 1'b1;
						end else begin
							rec[n] = mk_res(KIND_DONE, 8'h00, TYPE_STRING, tok_start_q,
								pos_q + 32'd1, ERR_TOO_LONG);
						end
						n = n + 1'b1;
						mode_n = MODE_IDLE;
					end else begin
						do_append = 1'b1;
					end
				end
				MODE_SPACE: begin
					if (!is_blank(char_s1)) begin
						rec[n] = mk_res(KIND_DONE, 8'h00, TYPE_SPACE, tok_start_q, pos_q,
							ERR_TOO_LONG);
						n = n + 1'b1;
						start_new = 1'b1;
					end
				end
				default: begin
					start_new = 1'b1;
				end
			endcase

			if (start_new) begin
				tok_start_n = pos_q;
				len_n       = '0;
				mode_n      = MODE_IDLE;
				if (is_digit(char_s1)) begin
					mode_n    = MODE_NUMBER;
					do_append = 1'b1;
				end else if (is_letter(char_s1)) begin
					mode_n    = MODE_IDENT;
					do_append = 1'b1;
				end else if (is_quote(char_s1)) begin
					mode_n  = MODE_STRING;
					quote_n = char_s1;
				end else if (is_blank(char_s1)) begin
					if (emit_space) begin
						mode_n = MODE_SPACE;
						rec[n] = mk_res(KIND_VALUE, char_s1, TYPE_NUMBER, 32'd0, 32'd0,
							ERR_TOO_LONG);
						n = n + 1'b1;
					end
				end else if (!is_newline(char_s1)) begin
					rec[n] = mk_res(KIND_VALUE, char_s1, TYPE_NUMBER, 32'd0, 32'd0,
						ERR_TOO_LONG);
					n = n + 1'b1;
					rec[n] = mk_res(KIND_DONE, 8'h00, punct_type(char_s1), pos_q,
						pos_q + 32'd1, ERR_TOO_LONG);
					n = n + 1'b1;
				end
			end

			if (do_append) begin
				if (len_n >= LEN_LIMIT) begin
					rec[n] = mk_res(KIND_ERROR, 8'h00, TYPE_NUMBER, tok_start_n, pos_q,
						ERR_TOO_LONG);
					n = n + 1'b1;
					halted_n = 1'b1;
					mode_n   = MODE_IDLE;
				end else begin
					len_n  = len_n + 1'b1;
					rec[n] = mk_res(KIND_VALUE, char_s1, TYPE_NUMBER, 32'd0, 32'd0,
						ERR_TOO_LONG);
					n = n + 1'b1;
				end
			end
		end

		if (n != '0) begin
			rec[n - 1'b1].last = 1'b1;
		end
		bundle.cnt = n;
		bundle.rec = rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			quote_q     <= 8'h00;
			tok_start_q <= 32'd0;
			pos_q       <= 32'd0;
			len_q       <= '0;
			halted_q    <= 1'b0;
		end else if (push) begin
			mode_q      <= mode_n;
			quote_q     <= quote_n;
			tok_start_q <= tok_start_n;
			pos_q       <= pos_n;
			len_q       <= len_n;
			halted_q    <= halted_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("lexer left the halted state");
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |-> mode_q == MODE_IDLE)
		else $error("halted lexer holds an open token");
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LEN_LIMIT)
		else $error("token length passed its limit");
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |-> !push || bundle.cnt == '0)
		else $error("halted lexer produced a record");

endmodule

@@ rtl/core/bsl_fifo.sv @@
// Result queue: takes up to three records per transfer, hands out one per cycle
// while out_ready is high. Depends on bsl_pkg.
module bsl_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bsl_pkg::res_bundle_t bundle,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bsl_pkg::res_t        out_rec
);
	import bsl_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             mem [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] tail;
	logic             pop;
	logic [CNT_W-1:0] add;

	assign room      = count_q <= CNT_W'(FIFO_DEPTH - MAX_RES);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign tail      = head_q + count_q[PTR_W-1:0];
	assign add       = push ? CNT_W'(bundle.cnt) : '0;
	assign out_rec   = mem[head_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (push && (RES_CNT_W'(i) < bundle.cnt)) begin
				mem[tail + PTR_W'(i)] <= bundle.rec[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + add - CNT_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q + CNT_W'(bundle.cnt) <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> count_q != CNT_W'(FIFO_DEPTH))
		else $error("result queue filled while draining");

endmodule

@@ rtl/core/byte_stream_lexer.sv @@
// Byte stream lexer top level: configuration register, lexer core and result queue.
// A byte is held in the core's input register and its records are written to the result queue.
// Throughput: one byte per cycle while out_ready is high and each byte yields at most one
// record; bytes yielding two or three records are paced by the output at one record per cycle.
// Reset clears all lexer state, the queue and emit_space_tokens; after end of input or
// an error every byte is dropped until the next reset. Depends on bsl_pkg, bsl_core, bsl_fifo.
module byte_stream_lexer #(
	parameter int unsigned MAX_TOKEN_BYTES = bsl_pkg::MAX_TOKEN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        emit_space_tokens,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [7:0]  value_byte,
	output logic [3:0]  token_class,
	output logic [31:0] start_offset,
	output logic [31:0] end_offset,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	import bsl_pkg::*;

	logic        emit_space_q;
	logic        room, push;
	res_bundle_t bundle;
	res_t        out_rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_space_q <= 1'b0;
		end else if (cfg_valid) begin
			emit_space_q <= emit_space_tokens;
		end
	end

	bsl_core #(
		.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_byte   (char_byte),
		.end_of_input(end_of_input),
		.emit_space  (emit_space_q),
		.room        (room),
		.push        (push),
		.bundle      (bundle)
	);

	bsl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.bundle   (bundle),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec  (out_rec)
	);

	assign record_kind  = out_rec.kind;
	assign value_byte   = out_rec.value;
	assign token_class  = out_rec.ttype;
	assign start_offset = out_rec.start_off;
	assign end_offset   = out_rec.end_off;
	assign error_code   = out_rec.err;
	assign last_of_run  = out_rec.last;

endmodule

@@ tb/byte_stream_lexer_test.sv @@
// Self-checking testbench for byte_stream_lexer: a byte-level lexer model predicts every record
// and each output transfer is compared with the oldest prediction.
// Depends on bsl_pkg and the byte_stream_lexer RTL.
module byte_stream_lexer_test;
	import bsl_pkg::*;

	localparam int unsigned TOKEN_LIMIT = bsl_pkg::MAX_TOKEN_BYTES_DEF;
	localparam int unsigned SHOWN_FAULTS = 10;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		tok_type_t   ttype;
		logic [31:0] start_off;
		logic [31:0] end_off;
		err_t        err;
		logic        last;
	} lex_rec_t;

	typedef enum {CH_DIGIT, CH_ALPHA, CH_UNDER, CH_QUOTE, CH_BLANK, CH_EOL, CH_MISC} char_class_t;
	typedef enum {END_FLAG, END_NUL, END_OPEN_STRING, END_BAD_QUOTE, END_TOO_LONG} end_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        emit_space_tokens = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  record_kind;
	logic [7:0]  value_byte;
	logic [3:0]  token_class;
	logic [31:0] start_offset;
	logic [31:0] end_offset;
	logic [1:0]  error_code;
	logic        last_of_run;

	lex_rec_t    due_records[$];
	int unsigned faults = 0;
	int unsigned records_seen = 0;
	int unsigned bytes_offered = 0;
	int unsigned tx_pct = 0;
	int unsigned rx_pct = 0;
	int unsigned hold_request = 0;
	int unsigned rx_wait = 0;
	string       punct_marks = ";<>/{}|&=";

	// lexer state as seen by the testbench
	lex_mode_t   lex_state = MODE_IDLE;
	logic [7:0]  open_q = 8'h00;
	logic [31:0] tok_start = '0;
	logic [31:0] lex_pos = '0;
	int unsigned tok_len = 0;
	logic        lex_halted = 1'b0;
	logic        space_cfg = 1'b0;

	byte_stream_lexer #(.MAX_TOKEN_BYTES(TOKEN_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.emit_space_tokens(emit_space_tokens),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_byte(char_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.record_kind(record_kind),
		.value_byte(value_byte),
		.token_class(token_class),
		.start_offset(start_offset),
		.end_offset(end_offset),
		.error_code(error_code),
		.last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	function automatic char_class_t classify(logic [7:0] c);
		if (c >= "0" && c <= "9") return CH_DIGIT;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CH_ALPHA;
		if (c == "_") return CH_UNDER;
		if (c == 8'h22 || c == 8'h27) return CH_QUOTE;
		if (c == 8'h20 || c == 8'h09) return CH_BLANK;
		if (c == 8'h0A || c == 8'h0D) return CH_EOL;
		return CH_MISC;
	endfunction

	function automatic tok_type_t mark_type(logic [7:0] c);
		case (c)
			";":     return TYPE_SEMI;
			"<":     return TYPE_LT;
			">":     return TYPE_GT;
			"/":     return TYPE_SLASH;
			"{":     return TYPE_LBRACE;
			"}":     return TYPE_RBRACE;
			"|":     return TYPE_PIPE;
			"&":     return TYPE_AMP;
			"=":     return TYPE_EQUAL;
			default: return TYPE_OTHER;
		endcase
	endfunction

	function automatic void put_rec(kind_t k, logic [7:0] v, tok_type_t t, logic [31:0] s,
			logic [31:0] e, err_t er);
		lex_rec_t r;
		r.kind = k;
		r.value = v;
		r.ttype = t;
		r.start_off = s;
		r.end_off = e;
		r.err = er;
		r.last = 1'b0;
		due_records.push_back(r);
	endfunction

	function automatic void grow_token(logic [7:0] c, logic [31:0] pos);
		if (tok_len + 1 >= TOKEN_LIMIT - 1) begin
			put_rec(KIND_ERROR, '0, '0, tok_start, pos, ERR_TOO_LONG);
			lex_halted = 1'b1;
			lex_state = MODE_IDLE;
		end else begin
			tok_len++;
			put_rec(KIND_VALUE, c, '0, '0, '0, '0);
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, logic eoi);
		logic [31:0] pos;
		int unsigned mark;
		logic consumed;
		char_class_t cls;
		pos = lex_pos;
		mark = due_records.size();
		cls = classify(c);
		consumed = 1'b0;
		if (lex_halted) return;
		if (eoi || c == 8'h00) begin
			if (lex_state == MODE_STRING) begin
				put_rec(KIND_ERROR, '0, '0, tok_start, pos, ERR_UNTERMINATED);
			end else begin
				case (lex_state)
					MODE_NUMBER: put_rec(KIND_DONE, '0, TYPE_NUMBER, tok_start, pos, '0);
					MODE_IDENT:  put_rec(KIND_DONE, '0, TYPE_IDENT, tok_start, pos, '0);
					MODE_SPACE:  put_rec(KIND_DONE, '0, TYPE_SPACE, tok_start, pos, '0);
					default:     ;
				endcase
				put_rec(KIND_END, '0, '0, pos, pos, '0);
			end
			lex_state = MODE_IDLE;
			lex_halted = 1'b1;
		end else begin
			lex_pos = pos + 1;
			case (lex_state)
				MODE_NUMBER: begin
					if (cls == CH_DIGIT) begin
						grow_token(c, pos);
						consumed = 1'b1;
					end else begin
						put_rec(KIND_DONE, '0, TYPE_NUMBER, tok_start, pos, '0);
					end
				end
				MODE_IDENT: begin
					if (cls == CH_DIGIT || cls == CH_ALPHA || cls == CH_UNDER) begin
						grow_token(c, pos);
						consumed = 1'b1;
					end else begin
						put_rec(KIND_DONE, '0, TYPE_IDENT, tok_start, pos, '0);
					end
				end
				MODE_STRING: begin
					consumed = 1'b1;
					if (cls == CH_QUOTE) begin
						if (c != open_q) begin
							put_rec(KIND_ERROR, '0, '0, tok_start, pos, ERR_QUOTE_MISMATCH);
							lex_halted = 1'b1;
						end else begin
							put_rec(KIND_DONE, '0, TYPE_STRING, tok_start, pos + 1, '0);
						end
						lex_state = MODE_IDLE;
					end else begin
						grow_token(c, pos);
					end
				end
				MODE_SPACE: begin
					if (cls == CH_BLANK) consumed = 1'b1;
					else put_rec(KIND_DONE, '0, TYPE_SPACE, tok_start, pos, '0);
				end
				default: ;
			endcase
			if (!consumed) begin
				lex_state = MODE_IDLE;
				tok_start = pos;
				tok_len = 0;
				case (cls)
					CH_DIGIT: begin
						lex_state = MODE_NUMBER;
						grow_token(c, pos);
					end
					CH_ALPHA: begin
						lex_state = MODE_IDENT;
						grow_token(c, pos);
					end
					CH_QUOTE: begin
						lex_state = MODE_STRING;
						open_q = c;
					end
					CH_BLANK: begin
						if (space_cfg) begin
							lex_state = MODE_SPACE;
							put_rec(KIND_VALUE, c, '0, '0, '0, '0);
						end
					end
					CH_EOL: ;
					default: begin
						put_rec(KIND_VALUE, c, '0, '0, '0, '0);
						put_rec(KIND_DONE, '0, mark_type(c), pos, pos + 1, '0);
					end
				endcase
			end
		end
		if (due_records.size() > mark) due_records[due_records.size() - 1].last = 1'b1;
	endfunction

	function automatic int unsigned idle_len(int unsigned pct);
		if (pct == 0 || $urandom_range(99) >= pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(30, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255, 1)); while (c == 8'h22 || c == 8'h27);
		return c;
	endfunction

	function automatic logic [7:0] ident_byte();
		int unsigned r;
		r = $urandom_range(62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return "_";
	endfunction

	function automatic logic [7:0] letter_byte();
		return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic void report_fault(string what, lex_rec_t want, lex_rec_t seen);
		faults++;
		if (faults <= SHOWN_FAULTS)
			$display("record %0d %s: want k=%0d v=%02h t=%0d s=%0d e=%0d err=%0d last=%0d,",
				records_seen, what, want.kind, want.value, want.ttype, want.start_off,
				want.end_off, want.err, want.last,
				" got k=%0d v=%02h t=%0d s=%0d e=%0d err=%0d last=%0d",
				seen.kind, seen.value, seen.ttype, seen.start_off, seen.end_off, seen.err,
				seen.last);
	endfunction

	always @(posedge clk) begin : check_records
		lex_rec_t seen;
		lex_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {record_kind, value_byte, token_class, start_offset, end_offset, error_code,
				last_of_run};
			if (due_records.size() == 0) begin
				report_fault("unexpected", '0, seen);
			end else begin
				want = due_records.pop_front();
				if (seen !== want) report_fault("mismatch", want, seen);
			end
			records_seen++;
		end
	end

	always @(negedge clk) begin
		if (hold_request != 0) begin
			rx_wait = hold_request;
			hold_request = 0;
		end
		if (rx_wait != 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
			rx_wait = idle_len(rx_pct);
		end
	end

	task automatic offer_byte(input logic [7:0] c, input logic eoi);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		char_byte <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (!in_ready);
		tokenize_byte(c, eoi);
		bytes_offered++;
		gap = idle_len(tx_pct);
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic offer_text(input string s);
		for (int i = 0; i < s.len(); i++) offer_byte(s[i], 1'b0);
	endtask

	task automatic settle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_space_cfg(input logic v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		emit_space_tokens <= v;
		do @(posedge clk); while (!cfg_ready);
		space_cfg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_lexeme;
		int unsigned r;
		logic [7:0] q;
		r = $urandom_range(99);
		if (r < 22) begin
			repeat ($urandom_range(6, 1)) offer_byte(digit_byte(), 1'b0);
		end else if (r < 44) begin
			offer_byte(letter_byte(), 1'b0);
			repeat ($urandom_range(6)) offer_byte(ident_byte(), 1'b0);
		end else if (r < 58) begin
			q = $urandom_range(1) ? 8'h22 : 8'h27;
			offer_byte(q, 1'b0);
			repeat ($urandom_range(8)) offer_byte(text_byte(), 1'b0);
			offer_byte(q, 1'b0);
		end else if (r < 68) begin
			repeat ($urandom_range(4, 1)) offer_byte($urandom_range(1) ? 8'h20 : 8'h09, 1'b0);
		end else if (r < 74) begin
			offer_byte($urandom_range(1) ? 8'h0A : 8'h0D, 1'b0);
		end else if (r < 88) begin
			offer_byte(punct_marks[$urandom_range(8)], 1'b0);
		end else begin
			offer_byte(text_byte(), 1'b0);
		end
	endtask

	task automatic test_directed;
		write_space_cfg(1'b0);
		tx_pct = 0;
		rx_pct = 0;
		offer_text("12;a_9 _<>/{}|&=");
		offer_text("'a'\"\"");
		offer_byte(8'h0A, 1'b0);
		offer_byte(8'h0D, 1'b0);
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'h01, 1'b0);
	endtask

	task automatic test_space_tokens;
		write_space_cfg(1'b1);
		offer_text(" \t 7\t;");
	endtask

	task automatic test_random;
		int unsigned goal;
		for (int ph = 0; ph < 3; ph++) begin
			write_space_cfg(ph != 1);
			tx_pct = (ph == 0) ? 0 : (ph == 1) ? 30 : 10;
			rx_pct = (ph == 0) ? 0 : (ph == 1) ? 30 : 50;
			goal = bytes_offered + 20;
			while (bytes_offered < goal) send_random_lexeme();
		end
	endtask

	task automatic test_backpressure;
		settle();
		tx_pct = 0;
		rx_pct = 0;
		hold_request = 80;
		repeat (24) offer_byte(punct_marks[$urandom_range(8)], 1'b0);
	endtask

	task automatic test_long_token;
		logic [7:0] q;
		write_space_cfg(1'($urandom_range(1)));
		tx_pct = 15;
		rx_pct = 15;
		offer_byte(";", 1'b0);
		case ($urandom_range(2))
			0: begin
				repeat (TOKEN_LIMIT - 2) offer_byte(digit_byte(), 1'b0);
			end
			1: begin
				offer_byte(letter_byte(), 1'b0);
				repeat (TOKEN_LIMIT - 3) offer_byte(ident_byte(), 1'b0);
			end
			default: begin
				q = $urandom_range(1) ? 8'h22 : 8'h27;
				offer_byte(q, 1'b0);
				repeat (TOKEN_LIMIT - 2) offer_byte(text_byte(), 1'b0);
				offer_byte(q, 1'b0);
			end
		endcase
		offer_byte(";", 1'b0);
	endtask

	task automatic test_halt;
		end_kind_t how;
		logic [7:0] q;
		write_space_cfg(1'($urandom_range(1)));
		tx_pct = 20;
		rx_pct = 20;
		how = end_kind_t'($urandom_range(4));
		offer_byte(";", 1'b0);
		case (how)
			END_FLAG, END_NUL: begin
				case ($urandom_range(3))
					0: offer_byte("7", 1'b0);
					1: offer_byte("q", 1'b0);
					2: offer_byte(8'h20, 1'b0);
					default: ;
				endcase
				if (how == END_FLAG) offer_byte(8'($urandom_range(255)), 1'b1);
				else offer_byte(8'h00, 1'b0);
			end
			END_OPEN_STRING: begin
				offer_byte($urandom_range(1) ? 8'h22 : 8'h27, 1'b0);
				repeat ($urandom_range(3)) offer_byte(text_byte(), 1'b0);
				offer_byte(8'h00, 1'($urandom_range(1)));
			end
			END_BAD_QUOTE: begin
				q = $urandom_range(1) ? 8'h22 : 8'h27;
				offer_byte(q, 1'b0);
				repeat ($urandom_range(3)) offer_byte(text_byte(), 1'b0);
				offer_byte(q ^ 8'h05, 1'b0);
			end
			default: begin
				repeat (TOKEN_LIMIT - 1) offer_byte("5", 1'b0);
			end
		endcase
		for (int n = 0; n < 8; n++) offer_byte(8'($urandom_range(255)), n[0]);
		write_space_cfg(!space_cfg);
		repeat (4) offer_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_space_tokens();
		test_random();
		test_backpressure();
		test_long_token();
		test_halt();
		settle();
		repeat (8) @(posedge clk);
		if (faults == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/bsl_pkg.sv
rtl/core/bsl_core.sv
rtl/core/bsl_fifo.sv
rtl/core/byte_stream_lexer.sv
tb/byte_stream_lexer_test.sv
